// ===== hdl/y2r_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types and fixed-point constants for the YUV 4:2:2 to RGB888 block.
// ----------------------------------------------------------------------------
package y2r_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ACC_W     = 25;   // holds every channel sum without overflow
    localparam int COEF_W    = 16;

    // 2.14 signed coefficients
    localparam logic signed [COEF_W-1:0] COEF_RV = 16'sd23061;  // 1.4075
    localparam logic signed [COEF_W-1:0] COEF_GU = 16'sd5661;   // 0.3455
    localparam logic signed [COEF_W-1:0] COEF_GV = 16'sd11746;  // 0.7169
    localparam logic signed [COEF_W-1:0] COEF_BU = 16'sd29147;  // 1.7790

    localparam logic [7:0] CHANNEL_MAX = 8'd255;

    // pixel_format codes
    localparam logic FMT_GRAY  = 1'b0;
    localparam logic FMT_COLOR = 1'b1;
    localparam logic FMT_RESET = FMT_COLOR;

    // chroma contributions shared by both pixels of a pair
    typedef struct packed {
        logic signed [ACC_W-1:0] r_term;
        logic signed [ACC_W-1:0] g_term;
        logic signed [ACC_W-1:0] b_term;
    } chroma_terms_t;

endpackage

// ===== hdl/yuv422_to_rgb888_pixel_pair.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv422_to_rgb888_pixel_pair
// Converts one YUV 4:2:2 pixel pair per word into two packed RGB888 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one pixel pair per word: two luma bytes, shared U and V,
//   and a frame-end mark. m_* channel returns the two packed pixels (red 23:16,
//   green 15:8, blue 7:0) with the frame-end mark alongside.
//   cfg_* channel writes pixel_format (0 gray, 1 colour); cfg_ready is always
//   high. Write it only while no words are in flight.
//   m_valid rises when the output register loads: the input register loads at
//   the accept edge, the output register from it when empty or being taken.
//   Throughput is one word per cycle while m_ready is high (two-stage register
//   pipeline); four constant multipliers are shared by both pixels of a pair.
//   Reset (aresetn low, synchronous) empties both stages and sets colour mode.
//   When m_ready is low the output word holds; an empty input stage still
//   takes one more word, after which s_ready drops until the output is taken.
// ----------------------------------------------------------------------------
module yuv422_to_rgb888_pixel_pair (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_pixel_format,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_luma_first,
    input  logic [7:0]  s_luma_second,
    input  logic [7:0]  s_chroma_u,
    input  logic [7:0]  s_chroma_v,
    input  logic        s_frame_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_pixel_first,
    output logic [23:0] m_pixel_second,
    output logic        m_frame_end_out
);

    logic        fmt_reg;
    logic        in_valid_reg;
    logic [7:0]  luma_first_reg;
    logic [7:0]  luma_second_reg;
    logic [7:0]  chroma_u_reg;
    logic [7:0]  chroma_v_reg;
    logic        frame_end_reg;
    logic        out_valid_reg;
    logic [23:0] pixel_first_reg;
    logic [23:0] pixel_second_reg;
    logic        frame_end_out_reg;
    logic [23:0] pixel_first_next;
    logic [23:0] pixel_second_next;
    logic        out_load;
    logic        in_load;

    y2r_pkg::chroma_terms_t terms;

    assign cfg_ready = 1'b1;
    assign out_load  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || out_load;
    assign in_load   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= y2r_pkg::FMT_RESET;
        end else if (cfg_valid) begin
            fmt_reg <= cfg_pixel_format;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            luma_first_reg  <= s_luma_first;
            luma_second_reg <= s_luma_second;
            chroma_u_reg    <= s_chroma_u;
            chroma_v_reg    <= s_chroma_v;
            frame_end_reg   <= s_frame_end;
        end
    end

    y2r_chroma_terms u_chroma (
        .chroma_u (chroma_u_reg),
        .chroma_v (chroma_v_reg),
        .terms    (terms)
    );

    y2r_pixel_conv u_conv_first (
        .pixel_format (fmt_reg),
        .luma         (luma_first_reg),
        .terms        (terms),
        .pixel        (pixel_first_next)
    );

    y2r_pixel_conv u_conv_second (
        .pixel_format (fmt_reg),
        .luma         (luma_second_reg),
        .terms        (terms),
        .pixel        (pixel_second_next)
    );

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pixel_first_reg   <= pixel_first_next;
            pixel_second_reg  <= pixel_second_next;
            frame_end_out_reg <= frame_end_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pixel_first   = pixel_first_reg;
    assign m_pixel_second  = pixel_second_reg;
    assign m_frame_end_out = frame_end_out_reg;

endmodule

// ===== hdl/y2r_chroma_terms.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_chroma_terms
// Removes the chroma offset and forms the coefficient products per channel.
// ----------------------------------------------------------------------------
module y2r_chroma_terms (
    input  logic [7:0]               chroma_u,
    input  logic [7:0]               chroma_v,
    output y2r_pkg::chroma_terms_t   terms
);

    logic signed [7:0]                      du;
    logic signed [7:0]                      dv;
    logic signed [y2r_pkg::COEF_W+7:0]      prod_rv;
    logic signed [y2r_pkg::COEF_W+7:0]      prod_gu;
    logic signed [y2r_pkg::COEF_W+7:0]      prod_gv;
    logic signed [y2r_pkg::COEF_W+7:0]      prod_bu;

    // x - 128 on a byte is just the top bit flipped, read as signed
    assign du = $signed({~chroma_u[7], chroma_u[6:0]});
    assign dv = $signed({~chroma_v[7], chroma_v[6:0]});

    assign prod_rv = y2r_pkg::COEF_RV * dv;
    assign prod_gu = y2r_pkg::COEF_GU * du;
    assign prod_gv = y2r_pkg::COEF_GV * dv;
    assign prod_bu = y2r_pkg::COEF_BU * du;

    always_comb begin
        terms.r_term = y2r_pkg::ACC_W'(prod_rv);
        terms.g_term = -y2r_pkg::ACC_W'(prod_gu) - y2r_pkg::ACC_W'(prod_gv);
        terms.b_term = y2r_pkg::ACC_W'(prod_bu);
    end

endmodule

// ===== hdl/y2r_pixel_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pixel_conv
// Adds luma to chroma terms, clamps each channel, packs a pixel (grey: luma).
// ----------------------------------------------------------------------------
module y2r_pixel_conv (
    input  logic                     pixel_format,
    input  logic [7:0]               luma,
    input  y2r_pkg::chroma_terms_t   terms,
    output logic [23:0]              pixel
);

    logic signed [y2r_pkg::ACC_W-1:0] base;
    logic signed [y2r_pkg::ACC_W-1:0] sum_r;
    logic signed [y2r_pkg::ACC_W-1:0] sum_g;
    logic signed [y2r_pkg::ACC_W-1:0] sum_b;
    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;

    function automatic logic [7:0] clamp_channel(input logic signed [y2r_pkg::ACC_W-1:0] acc);
        logic [y2r_pkg::ACC_W-y2r_pkg::FRAC_BITS-2:0] whole;
        logic [7:0]                                   res;
        whole = acc[y2r_pkg::ACC_W-2:y2r_pkg::FRAC_BITS];
        if (acc[y2r_pkg::ACC_W-1]) begin
            res = 8'd0;
        end else if (whole > y2r_pkg::CHANNEL_MAX) begin
            res = y2r_pkg::CHANNEL_MAX;
        end else begin
            res = whole[7:0];
        end
        return res;
    endfunction

    assign base  = $signed({{(y2r_pkg::ACC_W-8-y2r_pkg::FRAC_BITS){1'b0}}, luma,
                            {y2r_pkg::FRAC_BITS{1'b0}}});
    assign sum_r = base + terms.r_term;
    assign sum_g = base + terms.g_term;
    assign sum_b = base + terms.b_term;

    always_comb begin
        if (pixel_format == y2r_pkg::FMT_GRAY) begin
            red   = luma;
            green = luma;
            blue  = luma;
        end else begin
            red   = clamp_channel(sum_r);
            green = clamp_channel(sum_g);
            blue  = clamp_channel(sum_b);
        end
        pixel = {red, green, blue};
    end

endmodule

// ===== tb/yuv422_to_rgb888_pixel_pair_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv422_to_rgb888_pixel_pair_tb
// Self-checking bench for the YUV 4:2:2 pair to RGB888 converter. A queue-fed
// driver and a clocked monitor exercise the valid/ready channels with random
// idle bursts. Each accepted word is converted by a local fixed-point model and
// compared field by field with the result words, across colour and grey modes.
// ----------------------------------------------------------------------------
module yuv422_to_rgb888_pixel_pair_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PAIRS = 366;   // per random phase, five phases
    localparam int SHIFT        = 14;
    localparam int K_RV         = 23061;
    localparam int K_GU         = 5661;
    localparam int K_GV         = 11746;
    localparam int K_BU         = 29147;

    typedef struct {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       frame_end;
    } yuv_pair_t;

    typedef struct {
        logic [23:0] pixel_first;
        logic [23:0] pixel_second;
        logic        frame_end_out;
    } rgb_pair_t;

    logic        aclk;
    logic        aresetn          = 1'b0;
    logic        cfg_valid        = 1'b0;
    logic        cfg_pixel_format = y2r_pkg::FMT_GRAY;
    logic        cfg_ready;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_luma_first     = 8'd0;
    logic [7:0]  s_luma_second    = 8'd0;
    logic [7:0]  s_chroma_u       = 8'd0;
    logic [7:0]  s_chroma_v       = 8'd0;
    logic        s_frame_end      = 1'b0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [23:0] m_pixel_first;
    logic [23:0] m_pixel_second;
    logic        m_frame_end_out;

    yuv_pair_t   pair_backlog[$];
    rgb_pair_t   rgb_pending[$];
    yuv_pair_t   next_pair;
    rgb_pair_t   want_rgb;

    logic        fmt_model   = y2r_pkg::FMT_RESET;
    bit          idle_on     = 1'b1;
    bit          s_fire      = 1'b0;
    int          gap_left    = 0;
    int          stall_left  = 0;
    int          queued_count   = 0;
    int          accepted_count = 0;
    int          colour_count   = 0;
    int          grey_count     = 0;
    int          result_count   = 0;
    int          fail_count     = 0;
    int          cycle_count    = 0;

    yuv422_to_rgb888_pixel_pair u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_pixel_format (cfg_pixel_format),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_luma_first     (s_luma_first),
        .s_luma_second    (s_luma_second),
        .s_chroma_u       (s_chroma_u),
        .s_chroma_v       (s_chroma_v),
        .s_frame_end      (s_frame_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_first    (m_pixel_first),
        .m_pixel_second   (m_pixel_second),
        .m_frame_end_out  (m_frame_end_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // negative sums floor at zero, then truncate and saturate
    function automatic logic [7:0] channel_sat(input int acc);
        if (acc < 0)
            return 8'd0;
        if ((acc >>> SHIFT) > 255)
            return 8'd255;
        return 8'(acc >>> SHIFT);
    endfunction

    function automatic logic [23:0] rgb_from_yuv(input logic [7:0] y, input logic [7:0] u,
                                                 input logic [7:0] v, input logic fmt);
        int base;
        int du;
        int dv;
        base = int'(y) * (1 << SHIFT);
        du   = int'(u) - 128;
        dv   = int'(v) - 128;
        if (fmt == y2r_pkg::FMT_GRAY)
            return {y, y, y};
        return {channel_sat(base + K_RV * dv),
                channel_sat(base - K_GU * du - K_GV * dv),
                channel_sat(base + K_BU * du)};
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[7];
        corners = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 6)];
        return 8'($urandom);
    endfunction

    task automatic queue_pair(input logic [7:0] y1, input logic [7:0] y2,
                              input logic [7:0] u, input logic [7:0] v, input logic fe);
        yuv_pair_t p;
        p.luma_first  = y1;
        p.luma_second = y2;
        p.chroma_u    = u;
        p.chroma_v    = v;
        p.frame_end   = fe;
        pair_backlog.push_back(p);
        queued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || rgb_pending.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_format(input logic fmt);
        @(negedge aclk);
        cfg_valid        <= 1'b1;
        cfg_pixel_format <= fmt;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        fmt_model = fmt;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic fmt, input int n);
        write_format(fmt);
        repeat (n)
            queue_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                       $urandom_range(0, 15) == 0);
        wait_drained();
    endtask

    function automatic void note_mismatch(input string field, input logic [23:0] want,
                                          input logic [23:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s at word %0d: expected %06h, got %06h",
                     field, result_count, want, got);
    endfunction

    // input driver: holds a word until taken, idles in random bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (idle_on && pair_backlog.size() != 0 && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 9);
                s_valid <= 1'b0;
            end else if (pair_backlog.size() != 0) begin
                next_pair = pair_backlog.pop_front();
                s_luma_first  <= next_pair.luma_first;
                s_luma_second <= next_pair.luma_second;
                s_chroma_u    <= next_pair.chroma_u;
                s_chroma_v    <= next_pair.chroma_v;
                s_frame_end   <= next_pair.frame_end;
                s_valid       <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predicts on input accept, checks on result accept
    always @(posedge aclk) begin
        s_fire = aresetn && s_valid && s_ready;
        if (s_fire) begin
            want_rgb.pixel_first   = rgb_from_yuv(s_luma_first, s_chroma_u, s_chroma_v,
                                                  fmt_model);
            want_rgb.pixel_second  = rgb_from_yuv(s_luma_second, s_chroma_u, s_chroma_v,
                                                  fmt_model);
            want_rgb.frame_end_out = s_frame_end;
            rgb_pending.push_back(want_rgb);
            accepted_count++;
            if (fmt_model == y2r_pkg::FMT_GRAY)
                grey_count++;
            else
                colour_count++;
        end
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (rgb_pending.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word %0d: %06h %06h %0b", result_count,
                             m_pixel_first, m_pixel_second, m_frame_end_out);
            end else begin
                want_rgb = rgb_pending.pop_front();
                if (m_pixel_first !== want_rgb.pixel_first)
                    note_mismatch("pixel_first", want_rgb.pixel_first, m_pixel_first);
                if (m_pixel_second !== want_rgb.pixel_second)
                    note_mismatch("pixel_second", want_rgb.pixel_second, m_pixel_second);
                if (m_frame_end_out !== want_rgb.frame_end_out)
                    note_mismatch("frame_end_out", 24'(want_rgb.frame_end_out),
                                  24'(m_frame_end_out));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, rgb_pending.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // colour mode straight out of reset: neutral chroma, chroma extremes
        queue_pair(8'd0,   8'd255, 8'd128, 8'd128, 1'b0);
        queue_pair(8'd255, 8'd0,   8'd128, 8'd128, 1'b1);
        queue_pair(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        queue_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        queue_pair(8'd0,   8'd255, 8'd0,   8'd255, 1'b0);
        queue_pair(8'd255, 8'd0,   8'd255, 8'd0,   1'b1);
        queue_pair(8'd128, 8'd128, 8'd0,   8'd255, 1'b0);
        queue_pair(8'd128, 8'd128, 8'd255, 8'd0,   1'b1);
        queue_pair(8'd16,  8'd235, 8'd128, 8'd128, 1'b0);
        queue_pair(8'd1,   8'd254, 8'd127, 8'd129, 1'b0);
        wait_drained();

        // grey mode: chroma must have no effect
        write_format(y2r_pkg::FMT_GRAY);
        queue_pair(8'd0,   8'd255, 8'd0,   8'd255, 1'b1);
        queue_pair(8'd255, 8'd0,   8'd255, 8'd0,   1'b0);
        queue_pair(8'd170, 8'd85,  8'd128, 8'd128, 1'b1);
        queue_pair(8'd85,  8'd170, 8'd0,   8'd0,   1'b0);
        queue_pair(8'd0,   8'd0,   8'd255, 8'd255, 1'b0);
        queue_pair(8'd255, 8'd255, 8'd0,   8'd0,   1'b1);
        wait_drained();

        random_phase(y2r_pkg::FMT_COLOR, RANDOM_PAIRS);
        random_phase(y2r_pkg::FMT_GRAY,  RANDOM_PAIRS);
        random_phase(y2r_pkg::FMT_COLOR, RANDOM_PAIRS);
        random_phase(y2r_pkg::FMT_GRAY,  RANDOM_PAIRS);
        idle_on = 1'b0;
        random_phase(y2r_pkg::FMT_COLOR, RANDOM_PAIRS);

        repeat (10) @(posedge aclk);
        fail_count += rgb_pending.size();

        $display("converted %0d pixel pairs: %0d in colour mode, %0d in grey mode",
                 accepted_count, colour_count, grey_count);
        $display("%0d result words checked, %0d failures", result_count, fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== yuv422_to_rgb888_pixel_pair.f =====
hdl/y2r_pkg.sv
hdl/y2r_chroma_terms.sv
hdl/y2r_pixel_conv.sv
hdl/yuv422_to_rgb888_pixel_pair.sv
tb/yuv422_to_rgb888_pixel_pair_tb.sv
